@@ hdl/packet_airtime_calculator_top_defines.svh @@
// Assertion macros used by the checker file pac_chk.sv.
`ifndef PACKET_AIRTIME_CALCULATOR_TOP_DEFINES_SVH
`define PACKET_AIRTIME_CALCULATOR_TOP_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define PAC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same-cycle implication.
`define PAC_ASSERT_IMP(lbl, pre, post, msg) \
	`PAC_ASSERT(lbl, (pre) |-> (post), msg)

// Next-cycle implication.
`define PAC_ASSERT_NXT(lbl, pre, post, msg) \
	`PAC_ASSERT(lbl, (pre) |=> (post), msg)

`endif

@@ hdl/pac_pkg.sv @@
package pac_pkg;

	// Divider geometry
	localparam int unsigned SmallNw = 12;
	localparam int unsigned SmallDw = 6;
	localparam int unsigned BigNw   = 32;
	localparam int unsigned BigDw   = 19;

	// Modulation codes
	localparam logic [1:0] MOD_CHIRP = 2'd0;
	localparam logic [1:0] MOD_FSK   = 2'd1;

	localparam logic [2:0] BW_UNSUPPORTED = 3'd7;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_MOD   = 3'd1,
		ST_BAD_BW    = 3'd2,
		ST_BAD_SF    = 3'd3,
		ST_ZERO_RATE = 3'd4
	} status_t;

	// Per-packet context carried alongside the payload symbol divide
	typedef struct packed {
		status_t     status;
		logic        lora;
		logic        fsk;
		logic [3:0]  sf;
		logic [15:0] pre;
		logic [2:0]  cr;
		logic [2:0]  bwi;
		logic [16:0] bytes;
		logic [18:0] rate;
	} pac_ctx_t;

	// Context carried alongside the airtime divide
	typedef struct packed {
		status_t status;
		logic    fsk;
	} pac_tail_t;

	// 4 * truncated bandwidth in kHz
	function automatic logic [BigDw-1:0] bw_div(input logic [2:0] bwi);
		logic [BigDw-1:0] d;
		case (bwi)
			3'd0:    d = 19'd2000;
			3'd1:    d = 19'd1000;
			3'd2:    d = 19'd500;
			3'd3:    d = 19'd248;
			3'd4:    d = 19'd124;
			3'd5:    d = 19'd60;
			3'd6:    d = 19'd28;
			default: d = 19'd1;
		endcase
		return d;
	endfunction

endpackage

@@ hdl/pac_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module pac_div #(
	parameter int unsigned NW = 8,
	parameter int unsigned DW = 8,
	parameter int unsigned PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [PW-1:0] in_pay,
	output logic          out_valid,
	output logic [NW-1:0] out_quot,
	output logic [PW-1:0] out_pay
);

	// Partial remainder in the upper bits, dividend/quotient in the lower bits
	logic [NW+DW-1:0] acc_s [1:NW];
	logic [DW-1:0]    den_s [1:NW];
	logic [PW-1:0]    pay_s [1:NW];
	logic [NW:1]      vld_s;

	for (genvar i = 0; i < NW; i++) begin : g_step
		logic [NW+DW-1:0] a_in;
		logic [DW-1:0]    d_in;
		logic [PW-1:0]    p_in;
		logic             v_in;
		logic [NW+DW:0]   sh;
		logic [DW:0]      hi;
		logic [DW:0]      diff;
		logic             ge;
		logic [NW+DW-1:0] nxt;

		if (i == 0) begin : g_first
			assign a_in = {{DW{1'b0}}, in_num};
			assign d_in = in_den;
			assign p_in = in_pay;
			assign v_in = in_valid;
		end else begin : g_next
			assign a_in = acc_s[i];
			assign d_in = den_s[i];
			assign p_in = pay_s[i];
			assign v_in = vld_s[i];
		end

		// Shift, trial subtract, restore
		always_comb begin
			sh   = {a_in, 1'b0};
			hi   = sh[NW+DW:NW];
			ge   = (hi >= {1'b0, d_in});
			diff = hi - {1'b0, d_in};
			if (ge) begin
				nxt = {diff[DW-1:0], sh[NW-1:1], 1'b1};
			end else begin
				nxt = {hi[DW-1:0], sh[NW-1:0]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[i+1] <= nxt;
				den_s[i+1] <= d_in;
				pay_s[i+1] <= p_in;
			end
		end
	end

	assign out_valid = vld_s[NW];
	assign out_quot  = acc_s[NW][NW-1:0];
	assign out_pay   = pay_s[NW];

endmodule

@@ hdl/pac_front.sv @@
// Input decode: status checks, symbol-count numerator, FSK byte count.
module pac_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [1:0]            modulation,
	input  logic [2:0]            bandwidth_index,
	input  logic [18:0]           rate_value,
	input  logic [15:0]           preamble_length,
	input  logic [7:0]            payload_bytes,
	input  logic [2:0]            coding_rate,
	input  logic                  implicit_header,
	input  logic                  crc_absent,
	input  logic [3:0]            sync_word_bytes,
	output logic                  valid_s1,
	output pac_pkg::pac_ctx_t     ctx_s1,
	output logic [pac_pkg::SmallNw-1:0] num_s1,
	output logic [pac_pkg::SmallDw-1:0] den_s1
);

	pac_pkg::status_t             status;
	pac_pkg::pac_ctx_t            ctx;
	logic [3:0]                   sf;
	logic [11:0]                  pos_term;
	logic [7:0]                   neg_term;
	logic                         de;
	logic [pac_pkg::SmallDw-1:0]  den;
	logic [pac_pkg::SmallNw-1:0]  num;
	logic [16:0]                  bytes;

	// Status checks, bandwidth before spreading factor
	always_comb begin
		status = pac_pkg::ST_OK;
		case (modulation)
			pac_pkg::MOD_CHIRP: begin
				if (bandwidth_index == pac_pkg::BW_UNSUPPORTED) begin
					status = pac_pkg::ST_BAD_BW;
				end else if (rate_value < 19'd7 || rate_value > 19'd12) begin
					status = pac_pkg::ST_BAD_SF;
				end
			end
			pac_pkg::MOD_FSK: begin
				if (rate_value == 19'd0) begin
					status = pac_pkg::ST_ZERO_RATE;
				end
			end
			default: status = pac_pkg::ST_BAD_MOD;
		endcase
	end

	// Ceiling divide operands: (num + den - 1) / den, zero when num <= 0
	always_comb begin
		sf       = rate_value[3:0];
		pos_term = {1'b0, payload_bytes, 3'b000} + 12'd44;
		neg_term = {2'b00, sf, 2'b00} + (implicit_header ? 8'd20 : 8'd0);
		de       = (sf >= 4'd11);
		den      = {sf - (de ? 4'd2 : 4'd0), 2'b00};
		if (pos_term > {4'b0000, neg_term}) begin
			num = pos_term - {4'b0000, neg_term} + {6'b000000, den} - 12'd1;
		end else begin
			num = '0;
		end
		bytes = {1'b0, preamble_length} + {13'd0, sync_word_bytes} + 17'd1
			+ {9'd0, payload_bytes} + (crc_absent ? 17'd0 : 17'd2);
	end

	always_comb begin
		ctx        = '0;
		ctx.status = status;
		ctx.lora   = (modulation == pac_pkg::MOD_CHIRP) && (status == pac_pkg::ST_OK);
		ctx.fsk    = (modulation == pac_pkg::MOD_FSK) && (status == pac_pkg::ST_OK);
		ctx.sf     = sf;
		ctx.pre    = preamble_length;
		ctx.cr     = coding_rate;
		ctx.bwi    = bandwidth_index;
		ctx.bytes  = bytes;
		ctx.rate   = rate_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx;
			num_s1 <= num;
			den_s1 <= den;
		end
	end

endmodule

@@ hdl/packet_airtime_calculator_top.sv @@
// Packet airtime calculator.
// Slave stream s_*: one packet description per beat; s_tuser carries the
// modulation, s_tdata the remaining fields. Master stream m_*: one result
// per packet, airtime in ms on m_tdata and the status code on m_tuser.
// The cfg_* channel writes the FSK sync word byte count; it is always ready
// and should only be written while no packet is in flight. Reset value 3.
// From input beat to output beat a packet passes one decode stage, a
// 12-stage divider for the LoRa payload block count, two arithmetic stages,
// a 32-stage divider for the final airtime and the output register.
// Throughput is one packet per cycle while the receiver takes results; each
// divider retires one quotient bit per stage.
// The whole pipeline advances while the output register is empty or being
// taken; when the receiver stalls, s_tready drops and every stage holds.
// Reset clears all valid bits and restores the sync word count; no result is
// pending after reset.
module packet_airtime_calculator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// bandwidth_index[2:0], rate_value[21:3], preamble_length[37:22],
	// payload_bytes[45:38], coding_rate[48:46], implicit_header[49],
	// crc_absent[50], zero fill above
	input  logic [55:0] s_tdata,
	// modulation[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// airtime_ms[29:0], zero fill above
	output logic [31:0] m_tdata,
	// status[2:0]
	output logic [2:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);

	localparam int unsigned CtxW  = $bits(pac_pkg::pac_ctx_t);
	localparam int unsigned TailW = $bits(pac_pkg::pac_tail_t);

	logic                          adv;
	logic [3:0]                    sync_q;

	logic                          valid_s1;
	pac_pkg::pac_ctx_t             ctx_s1;
	logic [pac_pkg::SmallNw-1:0]   num_s1;
	logic [pac_pkg::SmallDw-1:0]   den_s1;

	logic                          sd_valid;
	logic [pac_pkg::SmallNw-1:0]   sd_quot;
	logic [CtxW-1:0]               sd_pay;
	pac_pkg::pac_ctx_t             sd_ctx;
	logic [3:0]                    cr_mult;

	logic                          valid_s2;
	pac_pkg::pac_ctx_t             ctx_s2;
	logic [15:0]                   sym_s2;
	logic [29:0]                   fnum_s2;

	logic                          valid_s3;
	pac_pkg::pac_ctx_t             ctx_s3;
	logic [19:0]                   quarter_s3;
	logic [29:0]                   fnum_s3;

	logic [pac_pkg::BigNw-1:0]     bd_num;
	logic [pac_pkg::BigDw-1:0]     bd_den;
	pac_pkg::pac_tail_t            bd_tail_in;
	logic                          bd_valid;
	logic [pac_pkg::BigNw-1:0]     bd_quot;
	logic [TailW-1:0]              bd_pay;
	pac_pkg::pac_tail_t            bd_tail;

	logic                          m_tvalid_q;
	logic [29:0]                   airtime_q;
	pac_pkg::status_t              status_q;

	// Global advance: output register free or being drained
	assign adv       = !m_tvalid_q || m_tready;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;

	// Sync word byte count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= 4'd3;
		end else if (cfg_valid) begin
			sync_q <= cfg_data;
		end
	end

	pac_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (adv),
		.in_valid        (s_tvalid),
		.modulation      (s_tuser),
		.bandwidth_index (s_tdata[2:0]),
		.rate_value      (s_tdata[21:3]),
		.preamble_length (s_tdata[37:22]),
		.payload_bytes   (s_tdata[45:38]),
		.coding_rate     (s_tdata[48:46]),
		.implicit_header (s_tdata[49]),
		.crc_absent      (s_tdata[50]),
		.sync_word_bytes (sync_q),
		.valid_s1        (valid_s1),
		.ctx_s1          (ctx_s1),
		.num_s1          (num_s1),
		.den_s1          (den_s1)
	);

	// Payload block count
	pac_div #(
		.NW (pac_pkg::SmallNw),
		.DW (pac_pkg::SmallDw),
		.PW (CtxW)
	) u_sdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (valid_s1),
		.in_num    (num_s1),
		.in_den    (den_s1),
		.in_pay    (ctx_s1),
		.out_valid (sd_valid),
		.out_quot  (sd_quot),
		.out_pay   (sd_pay)
	);

	assign sd_ctx  = pac_pkg::pac_ctx_t'(sd_pay);
	assign cr_mult = {1'b0, sd_ctx.cr} + 4'd4;

	// Stage 2: payload symbols, FSK dividend
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= sd_valid;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s2  <= sd_ctx;
			sym_s2  <= 16'({4'd0, sd_quot} * {12'd0, cr_mult}) + 16'd8;
			fnum_s2 <= 30'({13'd0, sd_ctx.bytes} * 30'd8000);
		end
	end

	// Stage 3: quarter-symbol count
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s3     <= ctx_s2;
			quarter_s3 <= {2'b00, ctx_s2.pre, 2'b00} + 20'd17 + {2'b00, sym_s2, 2'b00};
			fnum_s3    <= fnum_s2;
		end
	end

	// Airtime divide operands; error packets divide zero by one
	always_comb begin
		if (ctx_s3.lora) begin
			bd_num = {12'd0, quarter_s3} << ctx_s3.sf;
			bd_den = pac_pkg::bw_div(ctx_s3.bwi);
		end else if (ctx_s3.fsk) begin
			bd_num = {2'b00, fnum_s3};
			bd_den = ctx_s3.rate;
		end else begin
			bd_num = '0;
			bd_den = 19'd1;
		end
		bd_tail_in.status = ctx_s3.status;
		bd_tail_in.fsk    = ctx_s3.fsk;
	end

	pac_div #(
		.NW (pac_pkg::BigNw),
		.DW (pac_pkg::BigDw),
		.PW (TailW)
	) u_bdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (valid_s3),
		.in_num    (bd_num),
		.in_den    (bd_den),
		.in_pay    (bd_tail_in),
		.out_valid (bd_valid),
		.out_quot  (bd_quot),
		.out_pay   (bd_pay)
	);

	assign bd_tail = pac_pkg::pac_tail_t'(bd_pay);

	// Output register; FSK adds one millisecond
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= bd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			airtime_q <= bd_quot[29:0] + {29'd0, bd_tail.fsk};
			status_q  <= bd_tail.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, airtime_q};
	assign m_tuser  = status_q;

endmodule

@@ hdl/pac_chk.sv @@
`include "packet_airtime_calculator_top_defines.svh"

// Port-level checks on the airtime calculator.
module pac_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [55:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [3:0]  cfg_data
);

	// A stalled result beat holds
	`PAC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	// Input stalls while a result is held back
	`PAC_ASSERT_IMP(a_in_stall, m_tvalid && !m_tready, !s_tready, "input taken during output stall")

	// Error results carry zero airtime
	`PAC_ASSERT_IMP(a_err_zero, m_tvalid && m_tuser != pac_pkg::ST_OK, m_tdata == 32'd0, "nonzero airtime on error")

	// Status stays within its defined codes, upper fill stays zero
	`PAC_ASSERT_IMP(a_status_rng, m_tvalid, m_tuser <= pac_pkg::ST_ZERO_RATE && m_tdata[31:30] == 2'b00, "bad status or fill")

endmodule

bind packet_airtime_calculator_top pac_chk u_chk (.*);
